[rtl/dds_pkg.sv]
// dds_pkg: shared constants, calendar tables and types for the date day span unit.
// Used by dds_date_norm and date_day_span_unit; depends on nothing else.

package dds_pkg;

  // Field widths
  localparam int unsigned DayW  = 5;
  localparam int unsigned MonW  = 4;
  localparam int unsigned YearW = 14;
  localparam int unsigned SpanW = 23;
  localparam int unsigned LenW  = 5;   // month length, up to 31
  localparam int unsigned DoyW  = 9;   // day of year, up to 366

  // Calendar constants
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned MaxYearDef  = 9999;
  localparam int unsigned MonthsPerYr = 12;
  localparam int unsigned FebLeapLen  = 29;

  // Zero-based month index of February
  localparam logic [MonW-1:0] MonIdxFeb = MonW'(1);

  // Normalized date, handed from the repair logic into the pipeline
  typedef struct packed {
    logic [YearW-1:0] yrm1;      // clamped year minus one
    logic [DoyW-1:0]  doy;       // day of year, 1-based
    logic             repaired;  // day was out of range and became 1
  } dds_date_t;

  // Month length in a common year, zero-based month index
  function automatic logic [LenW-1:0] month_len(input logic [MonW-1:0] idx);
    logic [LenW-1:0] len;
    case (idx)
      4'd0:    len = 5'd31;
      4'd1:    len = 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before this one, common year
  function automatic logic [DoyW-1:0] days_before(input logic [MonW-1:0] idx);
    logic [DoyW-1:0] n;
    case (idx)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd59;
      4'd3:    n = 9'd90;
      4'd4:    n = 9'd120;
      4'd5:    n = 9'd151;
      4'd6:    n = 9'd181;
      4'd7:    n = 9'd212;
      4'd8:    n = 9'd243;
      4'd9:    n = 9'd273;
      4'd10:   n = 9'd304;
      4'd11:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

[rtl/date_day_span_unit.sv]
// date_day_span_unit: signed day count between two calendar dates, three stage pipeline.
// Depends on dds_pkg and dds_date_norm.
//
//   channel | direction | handshake                 | beat payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | in        | in_valid_i / in_ready_o   | first_/second_ day, month, year
//   out     | out       | out_valid_o / out_ready_i | span_days_o, day_repaired_o
//
// One beat is taken every cycle unless every stage is full and the output is stalled.
// Stage 1 repairs both dates, stage 2 forms the ordinals (constant multiply by 365),
// stage 3 subtracts them into the output register.
// Each stage has its own ready, so bubbles collapse and a stalled output
// still lets earlier stages fill.
// Reset clears the stage valid bits only; the data registers are not reset.

module date_day_span_unit import dds_pkg::*; #(
  parameter int unsigned MAX_YEAR = MaxYearDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [DayW-1:0]         first_day_i,
  input  logic [MonW-1:0]         first_month_i,
  input  logic [YearW-1:0]        first_year_i,
  input  logic [DayW-1:0]         second_day_i,
  input  logic [MonW-1:0]         second_month_i,
  input  logic [YearW-1:0]        second_year_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SpanW-1:0] span_days_o,
  output logic                    day_repaired_o
);

  // Largest year the clamp can produce, and the ordinal width it needs
  localparam int unsigned YearCap = (1 << YearW) - 1;
  localparam int unsigned EffMax  = (MAX_YEAR > YearCap) ? YearCap : MAX_YEAR;
  localparam int unsigned OrdW    = $clog2(EffMax * (DaysPerYear + 1) + 1);
  localparam int unsigned DiffW   = (OrdW + 1 > SpanW) ? OrdW + 1 : SpanW;

  // Stage 1: repaired dates
  dds_date_t date_a, date_b;

  dds_date_norm #(.MAX_YEAR(MAX_YEAR)) u_norm_a (
    .day_i   (first_day_i),
    .month_i (first_month_i),
    .year_i  (first_year_i),
    .date_o  (date_a)
  );

  dds_date_norm #(.MAX_YEAR(MAX_YEAR)) u_norm_b (
    .day_i   (second_day_i),
    .month_i (second_month_i),
    .year_i  (second_year_i),
    .date_o  (date_b)
  );

  logic            v1_q, v2_q, v3_q;
  logic            rdy1, rdy2, rdy3;
  dds_date_t       a1_q, b1_q;
  logic [OrdW-1:0] ord_a_d, ord_b_d, ord_a_q, ord_b_q;
  logic            rep2_q;
  logic [DiffW-1:0] diff_d;
  logic [SpanW-1:0] span_q;
  logic            rep3_q;

  // Per-stage ready: a stage takes a beat when empty or when it moves on
  assign rdy3       = ~v3_q | out_ready_i;
  assign rdy2       = ~v2_q | rdy3;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 1 register
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      a1_q <= date_a;
      b1_q <= date_b;
    end
  end

  // Stage 2: ordinal = 365 * (y-1) + (y-1)/4 + day of year
  assign ord_a_d = OrdW'(a1_q.yrm1) * OrdW'(DaysPerYear) + OrdW'(a1_q.yrm1 >> 2)
                 + OrdW'(a1_q.doy);
  assign ord_b_d = OrdW'(b1_q.yrm1) * OrdW'(DaysPerYear) + OrdW'(b1_q.yrm1 >> 2)
                 + OrdW'(b1_q.doy);

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      ord_a_q <= ord_a_d;
      ord_b_q <= ord_b_d;
      rep2_q  <= a1_q.repaired | b1_q.repaired;
    end
  end

  // Stage 3: difference, kept to the span width
  assign diff_d = DiffW'(ord_a_q) - DiffW'(ord_b_q);

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      span_q <= diff_d[SpanW-1:0];
      rep3_q <= rep2_q;
    end
  end

  assign out_valid_o    = v3_q;
  assign span_days_o    = span_q;
  assign day_repaired_o = rep3_q;

`ifndef SYNTH
  // Input only blocks when every stage is full and the output is stalled
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && !out_ready_i))
    else $error("input blocked without a full stalled pipeline");

  // A stalled stage 2 keeps its ordinals
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy3) |=> (v2_q && $stable(ord_a_q) && $stable(ord_b_q)))
    else $error("stage 2 changed while stalled");

  // Ordinals count from day 1
  a_ord_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (ord_a_q != '0 && ord_b_q != '0))
    else $error("zero ordinal in stage 2");
`endif

endmodule

[rtl/dds_date_norm.sv]
// dds_date_norm: repairs one calendar date and finds its day of year.
// Depends on dds_pkg (tables, widths, dds_date_t).

module dds_date_norm import dds_pkg::*; #(
  parameter int unsigned MAX_YEAR = MaxYearDef
) (
  input  logic [DayW-1:0]  day_i,
  input  logic [MonW-1:0]  month_i,
  input  logic [YearW-1:0] year_i,
  output dds_date_t        date_o
);

  localparam logic [16:0]      MaxYearW = 17'(MAX_YEAR);
  localparam logic [YearW-1:0] MaxYearY = YearW'(MAX_YEAR);

  logic [YearW-1:0] year_sat;
  logic [MonW-1:0]  mon_idx;
  logic             leap;
  logic [LenW-1:0]  len;
  logic             day_bad;
  logic [DayW-1:0]  day_fix;
  logic [DoyW-1:0]  leap_adj;

  // Year: zero becomes 1, above the limit saturates
  always_comb begin
    if (year_i == '0) begin
      year_sat = YearW'(1);
    end else if ({3'b000, year_i} > MaxYearW) begin
      year_sat = MaxYearY;
    end else begin
      year_sat = year_i;
    end
  end

  // Month out of range is taken as January
  assign mon_idx = (month_i >= MonW'(1) && month_i <= MonW'(MonthsPerYr))
                   ? month_i - MonW'(1) : '0;

  assign leap = (year_sat[1:0] == 2'b00);

  // Month length, with the leap February
  assign len = (mon_idx == MonIdxFeb && leap) ? LenW'(FebLeapLen) : month_len(mon_idx);

  // Day repair
  assign day_bad = (day_i == '0) || (day_i > len);
  assign day_fix = day_bad ? DayW'(1) : day_i;

  // Leap day counts once we are past February
  assign leap_adj = (mon_idx > MonIdxFeb && leap) ? DoyW'(1) : '0;

  assign date_o.yrm1     = year_sat - YearW'(1);
  assign date_o.doy      = days_before(mon_idx) + leap_adj + DoyW'(day_fix);
  assign date_o.repaired = day_bad;

endmodule

[tb/date_day_span_unit_test.sv]
// date_day_span_unit_test: self-checking bench for date_day_span_unit.
// A date table and random date pairs are sent; each result is compared with a typed-in value or a local calendar model.
// Depends on dds_pkg and the RTL of date_day_span_unit.
`timescale 1ns / 1ps

module date_day_span_unit_test;
  import dds_pkg::*;

  localparam int unsigned MonJan = 1;
  localparam int unsigned MonFeb = 2;
  localparam int unsigned MonDec = 12;
  localparam int unsigned NumRows = 23;
  localparam int unsigned NumRandom = 2000;

  // Common-year month lengths and days before each month
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned CumDays [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct packed {
    logic signed [SpanW-1:0] span;
    logic                    repaired;
  } day_span_t;

  typedef struct packed {
    logic [DayW-1:0]         fd;
    logic [MonW-1:0]         fm;
    logic [YearW-1:0]        fy;
    logic [DayW-1:0]         sd;
    logic [MonW-1:0]         sm;
    logic [YearW-1:0]        sy;
    logic                    known;  // expected result typed in below
    logic signed [SpanW-1:0] span;
    logic                    repaired;
  } date_row_t;

  // Directed dates: extremes, repairs, clamps, leap days
  date_row_t date_rows [NumRows] = '{
    '{1, 1, 1, 1, 1, 1, 1, 0, 0},
    '{31, 12, 9999, 1, 1, 1, 1, 3652133, 0},
    '{1, 1, 1, 31, 12, 9999, 1, -3652133, 0},
    '{31, 12, 16383, 1, 1, 0, 1, 3652133, 0},
    '{0, 1, 2000, 1, 1, 2000, 1, 0, 1},
    '{1, 1, 2000, 31, 2, 2001, 0, 0, 0},
    '{29, 2, 2024, 28, 2, 2024, 1, 1, 0},
    '{29, 2, 2023, 1, 2, 2023, 1, 0, 1},
    '{1, 3, 2024, 29, 2, 2024, 1, 1, 0},
    '{15, 0, 500, 15, 1, 500, 1, 0, 0},
    '{15, 13, 500, 15, 1, 500, 1, 0, 0},
    '{31, 15, 500, 31, 1, 500, 1, 0, 0},
    '{31, 4, 1999, 1, 4, 1999, 1, 0, 1},
    '{30, 4, 1999, 1, 5, 1999, 1, -1, 0},
    '{31, 12, 2023, 1, 1, 2024, 1, -1, 0},
    '{1, 1, 2025, 1, 1, 2024, 1, 366, 0},
    '{1, 1, 2024, 1, 1, 2023, 1, 365, 0},
    '{31, 1, 16383, 1, 2, 9999, 1, -1, 0},
    '{17, 8, 1969, 4, 7, 1776, 0, 0, 0},
    '{0, 0, 0, 31, 15, 16383, 0, 0, 0},
    '{30, 2, 4, 29, 2, 4, 0, 0, 0},
    '{1, 1, 4, 1, 1, 5, 1, -366, 0},
    '{1, 1, 100, 1, 1, 101, 1, -366, 0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [DayW-1:0] first_day = '0;
  logic [MonW-1:0] first_month = '0;
  logic [YearW-1:0] first_year = '0;
  logic [DayW-1:0] second_day = '0;
  logic [MonW-1:0] second_month = '0;
  logic [YearW-1:0] second_year = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SpanW-1:0] span_days;
  logic day_repaired;

  day_span_t span_q [$];
  int unsigned mismatches = 0;
  bit calm = 1'b0;  // no idling on either side while set

  date_day_span_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .first_day_i    (first_day),
    .first_month_i  (first_month),
    .first_year_i   (first_year),
    .second_day_i   (second_day),
    .second_month_i (second_month),
    .second_year_i  (second_year),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .span_days_o    (span_days),
    .day_repaired_o (day_repaired)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Month length under the every-fourth-year leap rule
  function automatic int unsigned month_days(input int unsigned mo, input int unsigned yr);
    if (mo == MonFeb && yr % 4 == 0) return FebLeapLen;
    return MonthDays[mo-1];
  endfunction

  // Ordinal day count of a repaired date; flags a day that was out of range
  function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                             input int unsigned y, inout logic fixed);
    int unsigned yr, mo, dy, n;
    yr = (y < 1) ? 1 : y;
    if (yr > MaxYearDef) yr = MaxYearDef;
    mo = (m < MonJan || m > MonDec) ? MonJan : m;
    dy = d;
    if (dy < 1 || dy > month_days(mo, yr)) begin
      dy = 1;
      fixed = 1'b1;
    end
    n = (yr - 1) * DaysPerYear + (yr - 1) / 4 + CumDays[mo-1];
    if (mo > MonFeb && yr % 4 == 0) n++;
    return n + dy;
  endfunction

  function automatic day_span_t predict_span(input logic [DayW-1:0] fd,
                                             input logic [MonW-1:0] fm,
                                             input logic [YearW-1:0] fy,
                                             input logic [DayW-1:0] sd,
                                             input logic [MonW-1:0] sm,
                                             input logic [YearW-1:0] sy);
    day_span_t r;
    int unsigned a, b;
    logic fixed;
    fixed = 1'b0;
    a = day_number(32'(fd), 32'(fm), 32'(fy), fixed);
    b = day_number(32'(sd), 32'(sm), 32'(sy), fixed);
    r.span = SpanW'(a - b);
    r.repaired = fixed;
    return r;
  endfunction

  // Offer one date pair; the beat is taken at the edge after a negedge with ready high
  task automatic send_dates(input logic [DayW-1:0] fd, input logic [MonW-1:0] fm,
                            input logic [YearW-1:0] fy, input logic [DayW-1:0] sd,
                            input logic [MonW-1:0] sm, input logic [YearW-1:0] sy,
                            input day_span_t want);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    first_day <= fd;
    first_month <= fm;
    first_year <= fy;
    second_day <= sd;
    second_month <= sm;
    second_year <= sy;
    do @(negedge clk); while (!in_ready);
    span_q.push_back(want);
    @(posedge clk);
  endtask

  // One random date: mostly well formed, some with edge days, some raw noise
  task automatic pick_date(output logic [DayW-1:0] d, output logic [MonW-1:0] m,
                           output logic [YearW-1:0] y);
    int unsigned mode, yr, mo, len;
    mode = $urandom_range(99);
    if (mode >= 80) begin
      d = DayW'($urandom_range(31));
      m = MonW'($urandom_range(15));
      y = YearW'($urandom_range(16383));
    end else begin
      case ($urandom_range(9))
        0: yr = $urandom_range(8, 1);
        1: yr = $urandom_range(MaxYearDef, MaxYearDef - 8);
        default: yr = $urandom_range(MaxYearDef, 1);
      endcase
      mo = $urandom_range(MonDec, MonJan);
      len = month_days(mo, yr);
      y = YearW'(yr);
      m = MonW'(mo);
      if (mode < 65) begin
        d = DayW'($urandom_range(len, 1));
      end else begin
        case ($urandom_range(4))
          0: d = 0;
          1: d = DayW'(len);
          2: d = DayW'((len < 31) ? len + 1 : 31);
          3: d = 29;
          default: d = 31;
        endcase
      end
    end
  endtask

  // Stimulus: date table first, then random pairs
  initial begin
    logic [DayW-1:0] fd, sd;
    logic [MonW-1:0] fm, sm;
    logic [YearW-1:0] fy, sy;
    day_span_t want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    for (int i = 0; i < NumRows; i++) begin
      if (date_rows[i].known) begin
        want.span = date_rows[i].span;
        want.repaired = date_rows[i].repaired;
      end else begin
        want = predict_span(date_rows[i].fd, date_rows[i].fm, date_rows[i].fy,
                            date_rows[i].sd, date_rows[i].sm, date_rows[i].sy);
      end
      send_dates(date_rows[i].fd, date_rows[i].fm, date_rows[i].fy,
                 date_rows[i].sd, date_rows[i].sm, date_rows[i].sy, want);
    end
    for (int i = 0; i < NumRandom; i++) begin
      calm = (i >= 900 && i < 1300);
      pick_date(fd, fm, fy);
      pick_date(sd, sm, sy);
      send_dates(fd, fm, fy, sd, sm, sy, predict_span(fd, fm, fy, sd, sm, sy));
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (span_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[date_day_span_unit] OK");
    end else begin
      $display("[date_day_span_unit] ERROR");
    end
    $finish;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 22);
  end

  // Result check; a beat seen at the negedge is taken at the next edge
  always @(negedge clk) begin
    day_span_t want;
    if (rst_n && out_valid && out_ready) begin
      if (span_q.size() == 0) begin
        $display("%0t: unexpected result beat, span %0d repaired %0b",
                 $time, span_days, day_repaired);
        mismatches++;
      end else begin
        want = span_q.pop_front();
        if (span_days !== want.span) begin
          $display("%0t: span_days expected %0d actual %0d", $time, want.span, span_days);
          mismatches++;
        end
        if (day_repaired !== want.repaired) begin
          $display("%0t: day_repaired expected %0b actual %0b",
                   $time, want.repaired, day_repaired);
          mismatches++;
        end
      end
    end
  end

  // Hang guard
  initial begin
    #2_000_000;
    $display("[date_day_span_unit] ERROR");
    $finish;
  end

endmodule
